/* hdl/vna_pkg.sv */
`default_nettype none

package vna_pkg;

  localparam int ELEM_W      = 16;
  localparam int TOTAL_W     = 39;
  localparam int NORM_W      = 24;
  localparam int COUNT_W     = 9;
  localparam int ROOT_W      = 20;
  localparam int SQRT_STEPS  = 20;
  localparam int COUNT_MAX   = 511;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [NORM_W-1:0]  NORM_MAX  = {NORM_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_L1   = 2'd0,
    MODE_L2   = 2'd1,
    MODE_LINF = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_FINISH
  } bstate_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;
  } in_t;

  typedef struct packed {
    logic [NORM_W-1:0]  norm_value;
    logic [COUNT_W-1:0] element_count;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic               ovf;
    mode_t              mode;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

/* hdl/vna_front.sv */
`default_nettype none

module vna_front #(
  parameter int MAX_LEN = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vna_pkg::in_t  in_word,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_data,
  input  vna_pkg::qstat_t qstat,
  output logic          push,
  output vna_pkg::job_t push_job
);
  import vna_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  mode_t              mode;
  logic [TOTAL_W-1:0] total;
  logic [CW-1:0]      seen;
  logic               ovf;

  logic [TOTAL_W-1:0] total_next;
  logic [CW-1:0]      seen_next;
  logic               ovf_next;

  logic               accept;
  logic [ELEM_W-1:0]  raw;
  logic [ELEM_W-1:0]  mag;
  logic [31:0]        sq;
  logic [TOTAL_W-1:0] addend;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;
  logic               full;
  logic [COUNT_W-1:0] count_sat;

  assign in_stall = qstat.full;
  assign accept   = in_valid & ~qstat.full;

  assign raw = in_word.element_value;
  assign mag = raw[ELEM_W-1] ? (~raw + 16'd1) : raw;
  assign sq  = 32'(mag) * 32'(mag);

  always_comb begin
    unique case (mode)
      MODE_L1: addend = TOTAL_W'(mag);
      MODE_L2: addend = TOTAL_W'(sq);
      default: addend = '0;
    endcase
  end

  assign sum     = {1'b0, total} + {1'b0, addend};
  assign sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign full    = (seen == CW'(MAX_LEN));

  always_comb begin
    total_next = total;
    seen_next  = seen;
    ovf_next   = ovf;
    if (full) begin
      ovf_next = 1'b1;
    end else begin
      seen_next = seen + CW'(1);
      unique case (mode)
        MODE_L1, MODE_L2: total_next = sum_sat;
        MODE_LINF: begin
          if (TOTAL_W'(mag) > total) begin
            total_next = TOTAL_W'(mag);
          end
        end
        default: total_next = total;
      endcase
    end
  end

  always_comb begin
    if (32'(seen_next) > 32'(COUNT_MAX)) begin
      count_sat = COUNT_W'(COUNT_MAX);
    end else begin
      count_sat = COUNT_W'(seen_next);
    end
  end

  assign push           = accept & in_word.last_element;
  assign push_job.total = total_next;
  assign push_job.count = count_sat;
  assign push_job.ovf   = ovf_next;
  assign push_job.mode  = mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_L1;
      total <= '0;
      seen  <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= mode_t'(cfg_data);
      end
      if (accept) begin
        if (in_word.last_element) begin
          total <= '0;
          seen  <= '0;
          ovf   <= 1'b0;
        end else begin
          total <= total_next;
          seen  <= seen_next;
          ovf   <= ovf_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/vna_queue.sv */
`default_nettype none

module vna_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vna_pkg::job_t   push_job,
  input  logic            pop,
  output vna_pkg::job_t   pop_job,
  output vna_pkg::qstat_t qstat
);
  import vna_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign qstat.full  = (fill == NW'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign pop_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + NW'(1);
        2'b01:   fill <= fill - NW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/vna_back.sv */
`default_nettype none

module vna_back (
  input  logic            clk,
  input  logic            rst,
  input  vna_pkg::qstat_t qstat,
  input  vna_pkg::job_t   pop_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output vna_pkg::out_t   out_word
);
  import vna_pkg::*;

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int STEP_W = $clog2(SQRT_STEPS);

  bstate_t state;
  bstate_t state_next;

  job_t              job;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [STEP_W-1:0] step;

  logic              step_en;
  logic              load;
  logic              last_step;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W+1:0]  rem_diff;
  logic [NORM_W-1:0] norm;

  assign last_step = (step == STEP_W'(SQRT_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          state_next = (pop_job.mode == MODE_L2) ? B_ROOT : B_FINISH;
        end
      end
      B_ROOT: begin
        if (last_step) begin
          state_next = B_FINISH;
        end
      end
      B_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    step_en = 1'b0;
    load    = 1'b0;
    unique case (state)
      B_IDLE:   pop     = !qstat.empty;
      B_ROOT:   step_en = 1'b1;
      B_FINISH: load    = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // restoring square root, one result bit per cycle
  assign rem_sh   = {rem, rad[RAD_W-1 -: 2]};
  assign trial    = (REM_W + 2)'({root, 2'b01});
  assign ge       = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;

  always_comb begin
    unique case (job.mode)
      MODE_L1, MODE_LINF: begin
        norm = (job.total > TOTAL_W'(NORM_MAX)) ? NORM_MAX : job.total[NORM_W-1:0];
      end
      MODE_L2:   norm = NORM_W'(root);
      default:   norm = '0;
    endcase
    if (job.ovf) begin
      norm = NORM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
      rad <= RAD_W'(pop_job.total);
      rem <= '0;
      root <= '0;
    end else if (step_en) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
    if (load) begin
      out_word.norm_value    <= norm;
      out_word.element_count <= job.count;
      out_word.overflow      <= job.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        step <= '0;
      end else if (step_en) begin
        step <= step + STEP_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/vector_norm_accumulator_top.sv */
// Vector norm accumulator.
// Input channel (in_valid / in_stall / in_word): one signed Q8.8 element per
// word, last_element marks the end of a vector. Elements are taken one per
// cycle; in_stall rises only while the result queue (two vectors) is full.
// Config: cfg_write / cfg_data set norm_mode (0 L1, 1 L2, 2 Linf); write it
// while the block is idle. The mode is sampled per element and on the last.
// Output channel (out_valid / out_stall / out_word): one word per vector with
// the norm (unsigned Q16.8), element count and overflow flag.
// From the last element, the vector is pushed into the queue, popped by the back
// end, run through the 20-step bit-serial square root (L2 only) and loaded
// into the registered output word. The back end finishes one vector before it
// pops another, overlapping the accumulation of the next vectors.
// Elements beyond MAX_LEN are dropped and the result saturates with overflow.
// A stalled output word holds; finished vectors wait in the queue meanwhile.
// Reset (rst, synchronous) clears the accumulator, queue and mode to L1.
`default_nettype none

module vector_norm_accumulator_top #(
  parameter int MAX_LEN = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vna_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output vna_pkg::out_t out_word,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_data
);
  import vna_pkg::*;

  logic   push;
  logic   pop;
  job_t   push_job;
  job_t   pop_job;
  qstat_t qstat;

  vna_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  vna_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .qstat   (qstat)
  );

  vna_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

/* hdl/vna_checker.sv */
`default_nettype none

module vna_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input vna_pkg::out_t out_word
);
  import vna_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.element_count != '0)
    else $error("result with zero element count");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.overflow |-> out_word.norm_value == NORM_MAX)
    else $error("overflow result not saturated");

endmodule

bind vector_norm_accumulator_top vna_checker u_vna_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

`default_nettype wire
